// ----- src/tcw_pkg.sv -----
// Shared constants for the text console writer.
`default_nettype none

package tcw_pkg;

  localparam int CONSOLE_COUNT_DEF = 4;
  localparam int REGION_WORDS_DEF  = 4096;
  localparam int LINE_WIDTH_DEF    = 80;
  localparam int SCREEN_WORDS_DEF  = 2000;

  localparam int CHAR_W   = 8;
  localparam int IDX_W    = 3;
  localparam int ADDR_W   = 14;
  localparam int ABS_W    = 18;

  localparam int IN_TDATA_W  = 16;
  localparam int IN_TUSER_W  = 1;
  localparam int OUT_TDATA_W = 64;
  localparam int OUT_TUSER_W = 3;

  localparam logic CMD_PUT    = 1'b0;
  localparam logic CMD_SELECT = 1'b1;

  localparam logic [CHAR_W-1:0] CH_NEWLINE   = 8'h0A;
  localparam logic [CHAR_W-1:0] CH_BACKSPACE = 8'h08;
  localparam logic [CHAR_W-1:0] CH_SPACE     = 8'h20;

  localparam logic [CHAR_W-1:0] ATTR_RESET = 8'h07;

endpackage

`default_nettype wire

// ----- src/text_console_writer.sv -----
// Text console writer: per-console cursor, view scrolling and video cell writes.
// Throughput: one request per cycle unless the output stalls; each console's
// cursor and view are read, updated and written back as its request moves from the
// input stage to the result stage, so back-to-back requests see fresh state.
// Reset: every console's cursor and view return to its region origin,
// console 0 is displayed, the attribute returns to 7 and both stages empty.
`default_nettype none

module text_console_writer #(
  parameter int CONSOLE_COUNT = tcw_pkg::CONSOLE_COUNT_DEF,
  parameter int REGION_WORDS  = tcw_pkg::REGION_WORDS_DEF,
  parameter int LINE_WIDTH    = tcw_pkg::LINE_WIDTH_DEF,
  parameter int SCREEN_WORDS  = tcw_pkg::SCREEN_WORDS_DEF
) (
  input  wire                              clk,
  input  wire                              rst_n,
  input  wire                              in_tvalid,
  output logic                             in_tready,
  // console_index [2:0], character [10:3], zero [15:11]
  input  wire  [tcw_pkg::IN_TDATA_W-1:0]   in_tdata,
  // command [0]
  input  wire  [tcw_pkg::IN_TUSER_W-1:0]   in_tuser,
  output logic                             out_tvalid,
  input  wire                              out_tready,
  // mem_addr [13:0], mem_char [21:14], mem_attr [29:22],
  // display_start [43:30], cursor_pos [57:44], zero [63:58]
  output logic [tcw_pkg::OUT_TDATA_W-1:0]  out_tdata,
  // mem_write [0], display_update [1], rejected [2]
  output logic [tcw_pkg::OUT_TUSER_W-1:0]  out_tuser,
  input  wire                              cfg_wr_en,
  input  wire  [tcw_pkg::CHAR_W-1:0]       cfg_wr_data
);
  import tcw_pkg::*;

  localparam int CIDX_W = (CONSOLE_COUNT > 1) ? $clog2(CONSOLE_COUNT) : 1;
  localparam int OFF_W  = $clog2(REGION_WORDS);
  localparam int COL_W  = $clog2(LINE_WIDTH);
  localparam int SUM_W  = $clog2(REGION_WORDS + SCREEN_WORDS + LINE_WIDTH) + 1;

  localparam logic [IDX_W:0]   CNT_LIM    = (IDX_W+1)'(CONSOLE_COUNT);
  localparam logic [SUM_W-1:0] REGION_S   = SUM_W'(REGION_WORDS);
  localparam logic [SUM_W-1:0] LINE_S     = SUM_W'(LINE_WIDTH);
  localparam logic [SUM_W-1:0] SCREEN_S   = SUM_W'(SCREEN_WORDS);
  localparam logic [SUM_W-1:0] NL_LIMIT_S = SUM_W'(REGION_WORDS - LINE_WIDTH);
  localparam logic [SUM_W-1:0] CH_LIMIT_S = SUM_W'(REGION_WORDS - 1);
  localparam logic [COL_W-1:0] COL_LAST   = COL_W'(LINE_WIDTH - 1);
  localparam logic [ABS_W-1:0] REGION_A   = ABS_W'(REGION_WORDS);

  // per-console state, kept as offsets inside the region
  logic [OFF_W-1:0]  cur_r  [CONSOLE_COUNT];
  logic [OFF_W-1:0]  view_r [CONSOLE_COUNT];
  logic [COL_W-1:0]  col_r  [CONSOLE_COUNT];
  logic [CIDX_W-1:0] shown_r;
  logic [CHAR_W-1:0] attr_r;

  // input stage
  logic              in_valid_r;
  logic              in_cmd_r;
  logic [IDX_W-1:0]  in_idx_r;
  logic [CHAR_W-1:0] in_char_r;

  // result stage
  logic              out_valid_r;
  logic              mem_write_r, mem_write_nxt;
  logic [ADDR_W-1:0] mem_addr_r, mem_addr_nxt;
  logic [CHAR_W-1:0] mem_char_r, mem_char_nxt;
  logic [CHAR_W-1:0] mem_attr_r, mem_attr_nxt;
  logic              disp_upd_r, disp_upd_nxt;
  logic [ADDR_W-1:0] disp_start_r, disp_start_nxt;
  logic [ADDR_W-1:0] cursor_pos_r, cursor_pos_nxt;
  logic              rejected_r, rejected_nxt;

  logic              advance;
  logic              fire;
  logic              reject;
  logic              upd_state;
  logic              put_write;
  logic [CHAR_W-1:0] put_char;
  logic [CIDX_W-1:0] c;
  logic [SUM_W-1:0]  cur, view, cur_nxt, view_nxt, wr_off;
  logic [COL_W-1:0]  col, col_nxt;
  logic [ABS_W-1:0]  origin;
  logic [ABS_W-1:0]  wr_abs, view_abs, cur_abs;

  assign advance   = !out_valid_r || out_tready;
  assign fire      = in_valid_r && advance;
  assign in_tready = !in_valid_r || advance;

  assign c      = in_idx_r[CIDX_W-1:0];
  assign reject = {1'b0, in_idx_r} >= CNT_LIM;
  assign cur    = SUM_W'(cur_r[c]);
  assign view   = SUM_W'(view_r[c]);
  assign col    = col_r[c];
  assign origin = ABS_W'(in_idx_r) * REGION_A;

  // cursor move and cell write
  always_comb begin
    cur_nxt   = cur;
    col_nxt   = col;
    wr_off    = cur;
    put_write = 1'b0;
    put_char  = '0;
    case (in_char_r)
      CH_NEWLINE: begin
        if (cur < NL_LIMIT_S) begin
          cur_nxt = cur - SUM_W'(col) + LINE_S;
          col_nxt = '0;
        end
      end
      CH_BACKSPACE: begin
        if (cur != '0) begin
          cur_nxt   = cur - SUM_W'(1);
          col_nxt   = (col == '0) ? COL_LAST : col - COL_W'(1);
          wr_off    = cur - SUM_W'(1);
          put_write = 1'b1;
          put_char  = CH_SPACE;
        end
      end
      default: begin
        if (cur < CH_LIMIT_S) begin
          cur_nxt   = cur + SUM_W'(1);
          col_nxt   = (col == COL_LAST) ? '0 : col + COL_W'(1);
          put_write = 1'b1;
          put_char  = in_char_r;
        end
      end
    endcase
  end

  // one line of scroll is always enough for a single cursor move
  always_comb begin
    view_nxt = view;
    if (in_cmd_r == CMD_PUT) begin
      if (cur_nxt >= view + SCREEN_S && view + SCREEN_S < REGION_S) begin
        view_nxt = view + LINE_S;
      end else if (cur_nxt < view && view != '0) begin
        view_nxt = view - LINE_S;
      end
    end
  end

  assign wr_abs   = origin + ABS_W'(wr_off);
  assign view_abs = origin + ABS_W'(view_nxt);
  assign cur_abs  = origin + ABS_W'((in_cmd_r == CMD_PUT) ? cur_nxt : cur);

  always_comb begin
    mem_write_nxt  = 1'b0;
    mem_char_nxt   = '0;
    mem_addr_nxt   = '0;
    mem_attr_nxt   = '0;
    disp_upd_nxt   = 1'b0;
    disp_start_nxt = '0;
    cursor_pos_nxt = '0;
    rejected_nxt   = reject;
    upd_state      = fire && !reject && (in_cmd_r == CMD_PUT);
    if (!reject) begin
      if (in_cmd_r == CMD_PUT) begin
        mem_write_nxt = put_write;
        mem_char_nxt  = put_char;
      end
      if (mem_write_nxt) begin
        mem_addr_nxt = wr_abs[ADDR_W-1:0];
        mem_attr_nxt = attr_r;
      end
      if (in_cmd_r == CMD_SELECT || c == shown_r) begin
        disp_upd_nxt   = 1'b1;
        disp_start_nxt = view_abs[ADDR_W-1:0];
        cursor_pos_nxt = cur_abs[ADDR_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < CONSOLE_COUNT; i++) begin
        cur_r[i]  <= '0;
        view_r[i] <= '0;
        col_r[i]  <= '0;
      end
      shown_r     <= '0;
      attr_r      <= ATTR_RESET;
      in_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        attr_r <= cfg_wr_data;
      end
      if (in_tready) begin
        in_valid_r <= in_tvalid;
      end
      if (advance) begin
        out_valid_r <= in_valid_r;
      end
      if (upd_state) begin
        cur_r[c]  <= cur_nxt[OFF_W-1:0];
        view_r[c] <= view_nxt[OFF_W-1:0];
        col_r[c]  <= col_nxt;
      end
      if (fire && !reject && in_cmd_r == CMD_SELECT) begin
        shown_r <= c;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      in_cmd_r  <= in_tuser[0];
      in_idx_r  <= in_tdata[IDX_W-1:0];
      in_char_r <= in_tdata[IDX_W+CHAR_W-1:IDX_W];
    end
    if (fire) begin
      mem_write_r  <= mem_write_nxt;
      mem_addr_r   <= mem_addr_nxt;
      mem_char_r   <= mem_char_nxt;
      mem_attr_r   <= mem_attr_nxt;
      disp_upd_r   <= disp_upd_nxt;
      disp_start_r <= disp_start_nxt;
      cursor_pos_r <= cursor_pos_nxt;
      rejected_r   <= rejected_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {6'b0, cursor_pos_r, disp_start_r, mem_attr_r, mem_char_r, mem_addr_r};
  assign out_tuser  = {rejected_r, disp_upd_r, mem_write_r};

endmodule

`default_nettype wire
